/* design/display_reply_frame_parser_macros.svh */
// Assertion macros shared by the frame parser modules.
`ifndef DISPLAY_REPLY_FRAME_PARSER_MACROS_SVH
`define DISPLAY_REPLY_FRAME_PARSER_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define DRFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define DRFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/drfp_pkg.sv */
package drfp_pkg;

  // Field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_COMMAND = 2'd2;

  // Register reset values.
  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h5A;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hA5;
  localparam logic [BYTE_W-1:0] REPLY_COMMAND_RST = 8'h83;

  // Shortest payload that carries command, address and a separate value.
  localparam logic [BYTE_W-1:0] MIN_REPLY_LEN = 8'd5;

  // Payload byte positions (counted from one) of command and address.
  localparam logic [BYTE_W-1:0] POS_COMMAND = 8'd1;
  localparam logic [BYTE_W-1:0] POS_ADDR_HI = 8'd2;
  localparam logic [BYTE_W-1:0] POS_ADDR_LO = 8'd3;

  typedef enum logic [3:0] {
    PH_HUNT_FIRST  = 4'b0001,
    PH_HUNT_SECOND = 4'b0010,
    PH_LENGTH      = 4'b0100,
    PH_PAYLOAD     = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              chunk_end;
  } rx_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] var_address;
    logic [WORD_W-1:0] var_value;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] reply_command;
  } cfg_t;

endpackage

/* design/drfp_if.sv */
// Received byte channel.
interface drfp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [drfp_pkg::BYTE_W-1:0] rx_byte;
  logic                        chunk_end;

  modport source (output valid, rx_byte, chunk_end, input ready);
  modport sink   (input valid, rx_byte, chunk_end, output ready);
endinterface

// Decoded reply channel.
interface drfp_result_if;
  logic                        valid;
  logic                        ready;
  logic [drfp_pkg::WORD_W-1:0] var_address;
  logic [drfp_pkg::WORD_W-1:0] var_value;

  modport source (output valid, var_address, var_value, input ready);
  modport sink   (input valid, var_address, var_value, output ready);
endinterface

// Register write channel.
interface drfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [drfp_pkg::CFG_IDX_W-1:0] index;
  logic [drfp_pkg::BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/drfp_in_stage.sv */
module drfp_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  drfp_pkg::rx_item_t item_i,
  output logic               valid_o,
  input  logic               take_i,
  output drfp_pkg::rx_item_t item_o
);
  import drfp_pkg::*;

  logic     valid_q, valid_d;
  rx_item_t item_q;
  logic     accept;

  // The register can take a new byte when empty or when its byte moves on.
  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* design/drfp_parser.sv */
`include "display_reply_frame_parser_macros.svh"

module drfp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  drfp_pkg::rx_item_t item_i,
  input  drfp_pkg::cfg_t     cfg_i,
  output logic               produce_o,
  output drfp_pkg::result_t  result_o
);
  import drfp_pkg::*;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic [BYTE_W-1:0] pos_q, pos_d;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [WORD_W-1:0] addr_q, addr_d;
  logic [WORD_W-1:0] tail_q, tail_d;
  logic              produce;
  logic [BYTE_W-1:0] b;

  assign b = item_i.rx_byte;

  // Frame state update for one received byte.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    tail_d  = tail_q;
    produce = 1'b0;
    unique case (phase_q)
      PH_HUNT_SECOND: begin
        // The second header byte wins over a repeated first header byte.
        if (b == cfg_i.header_second) begin
          phase_d = PH_LENGTH;
        end else if (b == cfg_i.header_first) begin
          phase_d = PH_HUNT_SECOND;
        end else begin
          phase_d = PH_HUNT_FIRST;
        end
      end
      PH_LENGTH: begin
        len_d   = b;
        pos_d   = '0;
        cmd_d   = '0;
        addr_d  = '0;
        tail_d  = '0;
        phase_d = (b == '0) ? PH_HUNT_FIRST : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        pos_d = pos_q + 8'd1;
        if (pos_d == POS_COMMAND) begin
          cmd_d = b;
        end else if (pos_d == POS_ADDR_HI) begin
          addr_d = {b, {BYTE_W{1'b0}}};
        end else if (pos_d == POS_ADDR_LO) begin
          addr_d = {addr_q[WORD_W-1:BYTE_W], b};
        end
        tail_d = {tail_q[BYTE_W-1:0], b};
        if (pos_d >= len_q) begin
          produce = (cmd_d == cfg_i.reply_command) && (len_q >= MIN_REPLY_LEN);
          phase_d = PH_HUNT_FIRST;
        end
      end
      default: begin
        phase_d = (b == cfg_i.header_first) ? PH_HUNT_SECOND : PH_HUNT_FIRST;
      end
    endcase
    // The end of a receive chunk drops any open frame.
    if (item_i.chunk_end) begin
      phase_d = PH_HUNT_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_FIRST;
      len_q   <= '0;
      pos_q   <= '0;
      cmd_q   <= '0;
      addr_q  <= '0;
      tail_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      tail_q  <= tail_d;
    end
  end

  assign produce_o            = step_i && produce;
  assign result_o.var_address = addr_d;
  assign result_o.var_value   = tail_d;

  `DRFP_ASSERT_ALWAYS(a_reset_hunts, clk_i, !rst_ni |=> phase_q == PH_HUNT_FIRST, "reset must restart the header hunt")
  `DRFP_ASSERT(a_chunk_end_hunts, clk_i, rst_ni, step_i && item_i.chunk_end |=> phase_q == PH_HUNT_FIRST, "chunk end must restart the header hunt")
  `DRFP_ASSERT(a_result_in_payload, clk_i, rst_ni, produce_o |-> phase_q == PH_PAYLOAD && pos_d >= len_q, "result outside the last payload byte")

endmodule

/* design/drfp_out_stage.sv */
`include "display_reply_frame_parser_macros.svh"

module drfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  drfp_pkg::result_t result_i,
  output logic              can_take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output drfp_pkg::result_t result_o
);
  import drfp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  // A new result may enter when the register is empty or drains this cycle.
  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  `DRFP_ASSERT(a_load_shows, clk_i, rst_ni, load_i |=> valid_q && data_q == $past(result_i), "loaded result not presented")
  `DRFP_ASSERT(a_load_has_room, clk_i, rst_ni, load_i |-> can_take_o, "result loaded over a pending one")
  `DRFP_ASSERT(a_stall_holds, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o), "stalled result changed")

endmodule

/* design/display_reply_frame_parser.sv */
// Reply frame parser: takes one received byte per clock cycle and hunts for
// the two-byte header, the length byte and the payload. A reply whose command
// matches reply_command and whose payload holds at least five bytes gives one
// result with the address from payload bytes two and three and the value from
// the last two payload bytes. Bytes are accepted back to back; the rate of one
// byte per cycle is set by the combinational frame state update between the
// input register and the result register. A result goes from its last byte in
// the input register through the frame state update into the result register,
// from which it can then be transferred out. While a result waits to be
// taken, the buffered byte behind it is not parsed, so the input stalls once
// the input register holds a byte as well. Register writes are always
// accepted and should only be made while the block is idle.
module display_reply_frame_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  drfp_byte_if.sink     in_i,
  drfp_result_if.source out_o,
  drfp_cfg_if.sink      cfg_i
);
  import drfp_pkg::*;

  cfg_t     cfg_q;
  rx_item_t in_item;
  rx_item_t stage_item;
  logic     stage_valid;
  logic     advance;
  logic     can_take;
  logic     produce;
  result_t  result;
  result_t  out_data;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HEADER_FIRST_RST;
      cfg_q.header_second <= HEADER_SECOND_RST;
      cfg_q.reply_command <= REPLY_COMMAND_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_i.data;
        CFG_HEADER_SECOND: cfg_q.header_second <= cfg_i.data;
        CFG_REPLY_COMMAND: cfg_q.reply_command <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_item.rx_byte   = in_i.rx_byte;
  assign in_item.chunk_end = in_i.chunk_end;

  // A buffered byte is parsed once the result register has room.
  assign advance = stage_valid && can_take;

  drfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .item_i     (in_item),
    .valid_o    (stage_valid),
    .take_i     (advance),
    .item_o     (stage_item)
  );

  drfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (stage_item),
    .cfg_i     (cfg_q),
    .produce_o (produce),
    .result_o  (result)
  );

  drfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (produce),
    .result_i    (result),
    .can_take_o  (can_take),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (out_data)
  );

  assign out_o.var_address = out_data.var_address;
  assign out_o.var_value   = out_data.var_value;

endmodule
